// ===== hw/rtl/lkvc_pkg.sv =====
// Package for the LRU key-value cache: sizing constants, opcodes and the
// request and response word types. Depends on nothing; used by the
// lru_key_value_cache top level.
package lkvc_pkg;

   // Number of physical slots in the cache.
   localparam int ENTRIES = 8;
   // Slot index width; the age rank of a slot uses the same width.
   localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   // Fill count width, wide enough to hold ENTRIES itself.
   localparam int FILL_W  = $clog2(ENTRIES + 1);
   // Width of the capacity register.
   localparam int CAP_W   = 4;
   // Common width for comparing the capacity register against ENTRIES.
   localparam int CMP_W   = (CAP_W > FILL_W) ? CAP_W : FILL_W;

   // Capacity after reset.
   localparam logic [CAP_W-1:0] ACTIVE_RESET = CAP_W'(8);
   // Value reported when a read does not return stored data.
   localparam logic signed [31:0] MISS_VALUE = -32'sd1;

   typedef enum logic {
      OP_GET = 1'b0,
      OP_PUT = 1'b1
   } opcode_type;

   typedef struct packed {
      opcode_type         opcode;
      logic signed [31:0] lookup_key;
      logic signed [31:0] write_value;
   } req_type;

   typedef struct packed {
      logic               found;
      logic signed [31:0] read_value;
      logic               evicted;
      logic signed [31:0] evicted_key;
   } rsp_type;

endpackage

// ===== hw/rtl/lru_key_value_cache.sv =====
// Fully associative key-value cache with least-recently-used replacement.
// A request word accepted into the request register gives its response from the response register.
// Throughput: one request per cycle; busy stays low, the whole lookup and the
// rank update run combinationally between the request and response registers.
// Reset clears valid bits, age ranks and the fill count at once and sets the
// capacity to 8; the receiver cannot stall, each response is shown for one cycle.
// Depends on lkvc_pkg.
module lru_key_value_cache (
   input  logic                            clock,
   input  logic                            reset,
   // Request channel.
   input  logic                            start,
   output logic                            busy,
   input  lkvc_pkg::req_type               req_data,
   // Response channel.
   output logic                            rsp_strobe,
   output lkvc_pkg::rsp_type               rsp_data,
   // Capacity register write channel.
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [lkvc_pkg::CAP_W-1:0]      csr_data
);

   localparam int ENTRIES = lkvc_pkg::ENTRIES;
   localparam int IDX_W   = lkvc_pkg::IDX_W;
   localparam int FILL_W  = lkvc_pkg::FILL_W;
   localparam int CMP_W   = lkvc_pkg::CMP_W;

   // Registers.
   logic                         req_valid_ff;
   lkvc_pkg::req_type            req_ff;
   logic                         rsp_strobe_ff, rsp_strobe_in;
   lkvc_pkg::rsp_type            rsp_ff, rsp_in;
   logic [lkvc_pkg::CAP_W-1:0]   active_ff;
   logic [ENTRIES-1:0]           slot_valid_ff, slot_valid_in;
   logic [IDX_W-1:0]             slot_rank_ff [ENTRIES];
   logic [IDX_W-1:0]             slot_rank_in [ENTRIES];
   logic signed [31:0]           slot_key_ff [ENTRIES];
   logic signed [31:0]           slot_key_in [ENTRIES];
   logic signed [31:0]           slot_value_ff [ENTRIES];
   logic signed [31:0]           slot_value_in [ENTRIES];
   logic [FILL_W-1:0]            fill_count_ff, fill_count_in;

   // Lookup signals.
   logic [CMP_W-1:0]             cap_wide;
   logic [FILL_W-1:0]            cap;
   logic [ENTRIES-1:0]           hit_vec;
   logic [ENTRIES-1:0]           victim_vec;
   logic                         hit_any;
   logic                         room;
   logic [IDX_W-1:0]             hit_idx;
   logic [IDX_W-1:0]             free_idx;
   logic [IDX_W-1:0]             victim_idx;
   logic [IDX_W-1:0]             tgt_idx;
   logic [IDX_W-1:0]             hit_rank;
   logic [IDX_W-1:0]             oldest_rank;
   logic                         is_put;

   // The cache never holds requests off and always takes a capacity write.
   assign busy      = 1'b0;
   assign csr_ready = 1'b1;

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;

   // Clamp the capacity register to the range 1..ENTRIES.
   always_comb begin
      cap_wide = CMP_W'(active_ff);
      if (cap_wide == '0) begin
         cap = FILL_W'(1);
      end else if (cap_wide > CMP_W'(ENTRIES)) begin
         cap = FILL_W'(ENTRIES);
      end else begin
         cap = cap_wide[FILL_W-1:0];
      end
   end

   // Parallel key compare and oldest-slot match across all slots. Valid slots
   // hold distinct ranks 0..fill_count-1, so the oldest has rank fill_count-1.
   assign oldest_rank = IDX_W'(fill_count_ff - FILL_W'(1));
   always_comb begin
      for (int i = 0; i < ENTRIES; i++) begin
         hit_vec[i]    = slot_valid_ff[i] && (slot_key_ff[i] == req_ff.lookup_key);
         victim_vec[i] = slot_valid_ff[i] && (slot_rank_ff[i] == oldest_rank);
      end
   end

   // Priority encoders: the lowest-numbered slot wins.
   always_comb begin
      hit_idx    = '0;
      free_idx   = '0;
      victim_idx = '0;
      for (int i = ENTRIES - 1; i >= 0; i--) begin
         if (hit_vec[i]) begin
            hit_idx = IDX_W'(i);
         end
         if (!slot_valid_ff[i]) begin
            free_idx = IDX_W'(i);
         end
         if (victim_vec[i]) begin
            victim_idx = IDX_W'(i);
         end
      end
   end

   assign hit_any  = |hit_vec;
   assign hit_rank = slot_rank_ff[hit_idx];
   assign room     = (fill_count_ff < cap);
   assign tgt_idx  = room ? free_idx : victim_idx;
   assign is_put   = (req_ff.opcode == lkvc_pkg::OP_PUT);

   // Next state of the slots and the response word.
   always_comb begin
      slot_valid_in = slot_valid_ff;
      fill_count_in = fill_count_ff;
      for (int i = 0; i < ENTRIES; i++) begin
         slot_rank_in[i]  = slot_rank_ff[i];
         slot_key_in[i]   = slot_key_ff[i];
         slot_value_in[i] = slot_value_ff[i];
      end
      rsp_strobe_in       = req_valid_ff;
      rsp_in.found        = hit_any;
      rsp_in.read_value   = lkvc_pkg::MISS_VALUE;
      rsp_in.evicted      = 1'b0;
      rsp_in.evicted_key  = '0;

      if (req_valid_ff) begin
         if (hit_any) begin
            // Hit: entries younger than the hit age by one, the hit becomes newest.
            for (int i = 0; i < ENTRIES; i++) begin
               if (slot_valid_ff[i] && (slot_rank_ff[i] < hit_rank)) begin
                  slot_rank_in[i] = slot_rank_ff[i] + IDX_W'(1);
               end
            end
            slot_rank_in[hit_idx] = '0;
            if (is_put) begin
               slot_value_in[hit_idx] = req_ff.write_value;
            end else begin
               rsp_in.read_value = slot_value_ff[hit_idx];
            end
         end else if (is_put) begin
            // Miss on a put: fill a free slot or replace the oldest entry.
            for (int i = 0; i < ENTRIES; i++) begin
               if (slot_valid_ff[i] && (IDX_W'(i) != tgt_idx)) begin
                  slot_rank_in[i] = slot_rank_ff[i] + IDX_W'(1);
               end
            end
            slot_valid_in[tgt_idx] = 1'b1;
            slot_rank_in[tgt_idx]  = '0;
            slot_key_in[tgt_idx]   = req_ff.lookup_key;
            slot_value_in[tgt_idx] = req_ff.write_value;
            if (room) begin
               fill_count_in = fill_count_ff + FILL_W'(1);
            end else begin
               rsp_in.evicted     = 1'b1;
               rsp_in.evicted_key = slot_key_ff[victim_idx];
            end
         end
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff  <= 1'b0;
         rsp_strobe_ff <= 1'b0;
         active_ff     <= lkvc_pkg::ACTIVE_RESET;
         slot_valid_ff <= '0;
         fill_count_ff <= '0;
         for (int i = 0; i < ENTRIES; i++) begin
            slot_rank_ff[i] <= '0;
         end
      end else begin
         req_valid_ff  <= start && !busy;
         rsp_strobe_ff <= rsp_strobe_in;
         if (csr_valid && csr_ready) begin
            active_ff <= csr_data;
         end
         slot_valid_ff <= slot_valid_in;
         fill_count_ff <= fill_count_in;
         for (int i = 0; i < ENTRIES; i++) begin
            slot_rank_ff[i] <= slot_rank_in[i];
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (start && !busy) begin
         req_ff <= req_data;
      end
      rsp_ff <= rsp_in;
      for (int i = 0; i < ENTRIES; i++) begin
         slot_key_ff[i]   <= slot_key_in[i];
         slot_value_ff[i] <= slot_value_in[i];
      end
   end

   // The fill count always equals the number of valid slots.
   a_fill_matches_valid: assert property (@(posedge clock) disable iff (reset)
      $countones(slot_valid_ff) == fill_count_ff)
      else $error("fill count differs from number of valid slots");

   // Slots are only ever added, never dropped.
   a_valid_never_drops: assert property (@(posedge clock) disable iff (reset)
      ($past(slot_valid_ff) & ~slot_valid_ff) == '0)
      else $error("a valid slot was cleared");

   // An eviction only comes from a missing key, and never changes the fill count.
   a_evict_is_miss: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe_ff && rsp_ff.evicted |-> !rsp_ff.found && $stable(fill_count_ff))
      else $error("eviction reported on a hit or with a fill count change");

   // No eviction happens while the cache still has room.
   a_evict_when_full: assert property (@(posedge clock) disable iff (reset)
      req_valid_ff && !hit_any && is_put && room |=> !rsp_ff.evicted)
      else $error("eviction while free capacity remained");

endmodule

// ===== bench/lru_key_value_cache_tb.sv =====
// Self-checking testbench for the lru_key_value_cache top level: directed table plus random
// get/put traffic, each response checked against a hand-written response or an in-bench LRU cache predictor.
// Depends on lkvc_pkg and the lru_key_value_cache RTL.
module lru_key_value_cache_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CLOCK_HIGH_NS  = 5;
   localparam int CLOCK_LOW_NS   = 5;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int POOL_SIZE      = 12;
   localparam int PHASE_COUNT    = 8;
   localparam int PHASE_WORDS    = 150;
   localparam logic [lkvc_pkg::CAP_W-1:0] DIRECTED_CAP = 4'd2;
   localparam logic [31:0] INT_MIN = 32'h8000_0000;
   localparam logic [31:0] INT_MAX = 32'h7fff_ffff;
   localparam logic [31:0] ALL_ONES = 32'hffff_ffff;

   // One row of the directed table; pinned rows carry a hand-written response.
   typedef struct {
      lkvc_pkg::req_type req;
      logic              pinned;
      lkvc_pkg::rsp_type rsp;
   } stim_row_type;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          start = 1'b0;
   logic                          busy;
   lkvc_pkg::req_type             req_data = '0;
   logic                          rsp_strobe;
   lkvc_pkg::rsp_type             rsp_data;
   logic                          csr_valid = 1'b0;
   logic                          csr_ready;
   logic [lkvc_pkg::CAP_W-1:0]    csr_data = '0;

   // Hand-written response travelling with the request word, sampled at acceptance.
   logic                          pin_valid = 1'b0;
   lkvc_pkg::rsp_type             pin_rsp = '0;

   // Predictor state: a copy of the cache contents and of the capacity register.
   logic                          slot_used [lkvc_pkg::ENTRIES];
   logic [31:0]                   slot_tag [lkvc_pkg::ENTRIES];
   logic [31:0]                   slot_data [lkvc_pkg::ENTRIES];
   int unsigned                   slot_age [lkvc_pkg::ENTRIES];
   int unsigned                   used_count;
   logic [lkvc_pkg::CAP_W-1:0]    capacity_reg;

   lkvc_pkg::rsp_type             expected_lookups [$];
   stim_row_type                  directed_rows [$];
   logic [31:0]                   key_pool [POOL_SIZE];
   int                            quiet_cycles = 0;
   logic                          failed = 1'b0;

   logic [lkvc_pkg::CAP_W-1:0] phase_cap [PHASE_COUNT] =
      '{4'd8, 4'd3, 4'd0, 4'd15, 4'd1, 4'd8, 4'd5, 4'd2};
   int phase_idle [PHASE_COUNT] = '{0, 54, 38, 0, 54, 38, 0, 54};

   lru_key_value_cache DUT (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   always begin
      #CLOCK_HIGH_NS clock = 1'b1;
      #CLOCK_LOW_NS  clock = 1'b0;
   end

   // Every valid slot younger than the limit gets one step older.
   function automatic void age_younger(int unsigned limit);
      for (int i = 0; i < lkvc_pkg::ENTRIES; i++) begin
         if (slot_used[i] && slot_age[i] < limit) begin
            slot_age[i] = slot_age[i] + 1;
         end
      end
   endfunction

   // Applies one get or put to the predictor state and returns the response it yields.
   function automatic lkvc_pkg::rsp_type lru_access(lkvc_pkg::req_type r);
      lkvc_pkg::rsp_type res;
      int                hit;
      int                slot;
      int unsigned       cap;
      int unsigned       oldest;
      res.found       = 1'b0;
      res.read_value  = lkvc_pkg::MISS_VALUE;
      res.evicted     = 1'b0;
      res.evicted_key = '0;
      cap = 32'(capacity_reg);
      if (cap == 0) begin
         cap = 1;
      end
      if (cap > lkvc_pkg::ENTRIES) begin
         cap = lkvc_pkg::ENTRIES;
      end
      hit = -1;
      for (int i = 0; i < lkvc_pkg::ENTRIES; i++) begin
         if (hit < 0 && slot_used[i] && slot_tag[i] == r.lookup_key) begin
            hit = i;
         end
      end
      if (hit >= 0) begin
         res.found = 1'b1;
         if (r.opcode == lkvc_pkg::OP_GET) begin
            res.read_value = slot_data[hit];
         end else begin
            slot_data[hit] = r.write_value;
         end
         age_younger(slot_age[hit]);
         slot_age[hit] = 0;
      end else if (r.opcode == lkvc_pkg::OP_PUT) begin
         slot = -1;
         // A free slot is used only while the fill is below the capacity.
         if (used_count < cap) begin
            for (int i = 0; i < lkvc_pkg::ENTRIES; i++) begin
               if (slot < 0 && !slot_used[i]) begin
                  slot = i;
               end
            end
         end
         if (slot >= 0) begin
            age_younger(lkvc_pkg::ENTRIES);
            used_count = used_count + 1;
         end else begin
            // Evict the least recent entry and reuse its slot.
            oldest = 0;
            for (int i = 0; i < lkvc_pkg::ENTRIES; i++) begin
               if (slot_used[i] && (slot < 0 || slot_age[i] > oldest)) begin
                  slot   = i;
                  oldest = slot_age[i];
               end
            end
            res.evicted     = 1'b1;
            res.evicted_key = slot_tag[slot];
            slot_used[slot] = 1'b0;
            age_younger(lkvc_pkg::ENTRIES);
         end
         slot_used[slot] = 1'b1;
         slot_tag[slot]  = r.lookup_key;
         slot_data[slot] = r.write_value;
         slot_age[slot]  = 0;
      end
      return res;
   endfunction

   function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         $display("%0t ns: %s mismatch, expected %h, got %h", $time, name, want, got);
         failed = 1'b1;
      end
   endfunction

   // Appends one row to the directed table.
   function automatic void add_row(lkvc_pkg::opcode_type op, logic [31:0] key,
                                   logic [31:0] value, logic pinned, logic found,
                                   logic [31:0] rd, logic ev, logic [31:0] evk);
      stim_row_type row;
      row.req.opcode      = op;
      row.req.lookup_key  = key;
      row.req.write_value = value;
      row.pinned          = pinned;
      row.rsp.found       = found;
      row.rsp.read_value  = rd;
      row.rsp.evicted     = ev;
      row.rsp.evicted_key = evk;
      directed_rows.push_back(row);
   endfunction

   // Keys are drawn mostly from a small pool so that hits, updates and evictions all occur.
   function automatic void refresh_pool();
      logic [31:0] corner [4];
      corner = '{INT_MIN, INT_MAX, 32'h0, ALL_ONES};
      for (int i = 0; i < POOL_SIZE; i++) begin
         key_pool[i] = ($urandom_range(9) == 0) ? corner[$urandom_range(3)] : $urandom;
      end
   endfunction

   function automatic lkvc_pkg::req_type random_request();
      lkvc_pkg::req_type r;
      r.opcode      = lkvc_pkg::opcode_type'($urandom_range(1));
      r.lookup_key  = ($urandom_range(9) < 8) ? key_pool[$urandom_range(POOL_SIZE - 1)]
                                              : $urandom;
      r.write_value = $urandom;
      return r;
   endfunction

   // Offers one request word after a random number of idle cycles and waits for acceptance.
   task automatic send_request(input lkvc_pkg::req_type r, input logic pinned,
                               input lkvc_pkg::rsp_type pr, input int idle_pct);
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start     <= 1'b1;
      req_data  <= r;
      pin_valid <= pinned;
      pin_rsp   <= pr;
      do @(posedge clock); while (busy);
   endtask

   // Lets every outstanding response come back; the block is idle afterwards.
   task automatic drain();
      start <= 1'b0;
      do @(posedge clock); while (expected_lookups.size() != 0);
   endtask

   task automatic write_capacity(input logic [lkvc_pkg::CAP_W-1:0] value);
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   // Predictor starts from the reset state.
   initial begin
      for (int i = 0; i < lkvc_pkg::ENTRIES; i++) begin
         slot_used[i] = 1'b0;
         slot_tag[i]  = '0;
         slot_data[i] = '0;
         slot_age[i]  = 0;
      end
      used_count   = 0;
      capacity_reg = lkvc_pkg::ACTIVE_RESET;
   end

   // Monitor: predicts at request acceptance, checks each response word, runs the watchdog.
   always @(posedge clock) begin : monitor
      lkvc_pkg::rsp_type predicted;
      lkvc_pkg::rsp_type want;
      logic              traffic;
      if (!reset) begin
         traffic = 1'b0;
         if (start && !busy) begin
            predicted = lru_access(req_data);
            expected_lookups.push_back(pin_valid ? pin_rsp : predicted);
            traffic = 1'b1;
         end
         if (rsp_strobe) begin
            traffic = 1'b1;
            if (expected_lookups.size() == 0) begin
               $display("%0t ns: response with none outstanding, got %h", $time, rsp_data);
               failed = 1'b1;
            end else begin
               want = expected_lookups.pop_front();
               check_field("found", 32'(want.found), 32'(rsp_data.found));
               check_field("read_value", want.read_value, rsp_data.read_value);
               check_field("evicted", 32'(want.evicted), 32'(rsp_data.evicted));
               check_field("evicted_key", want.evicted_key, rsp_data.evicted_key);
            end
         end
         if (csr_valid && csr_ready) begin
            capacity_reg = csr_data;
            traffic = 1'b1;
         end
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("lru_key_value_cache_tb: FAIL");
            $finish;
         end
         quiet_cycles <= traffic ? 0 : quiet_cycles + 1;
      end
   end

   // Stimulus: directed table at a capacity of two, then random phases over several capacities.
   initial begin
      // Hits, misses, an update, two evictions (one of key zero) and the integer extremes.
      add_row(lkvc_pkg::OP_GET, INT_MIN, 32'h0, 1, 0, ALL_ONES, 0, 0);
      add_row(lkvc_pkg::OP_PUT, INT_MIN, INT_MAX, 1, 0, ALL_ONES, 0, 0);
      add_row(lkvc_pkg::OP_PUT, INT_MAX, INT_MIN, 1, 0, ALL_ONES, 0, 0);
      add_row(lkvc_pkg::OP_GET, INT_MIN, ALL_ONES, 1, 1, INT_MAX, 0, 0);
      add_row(lkvc_pkg::OP_PUT, 32'h0, 32'h0, 1, 0, ALL_ONES, 1, INT_MAX);
      add_row(lkvc_pkg::OP_PUT, INT_MIN, 32'h5a5a5a5a, 1, 1, ALL_ONES, 0, 0);
      add_row(lkvc_pkg::OP_GET, INT_MIN, 32'h0, 1, 1, 32'h5a5a5a5a, 0, 0);
      add_row(lkvc_pkg::OP_GET, INT_MAX, 32'h0, 1, 0, ALL_ONES, 0, 0);
      add_row(lkvc_pkg::OP_PUT, ALL_ONES, ALL_ONES, 1, 0, ALL_ONES, 1, 32'h0);
      add_row(lkvc_pkg::OP_GET, ALL_ONES, 32'h0, 1, 1, ALL_ONES, 0, 0);
      // Alternating bit patterns and a half-word pattern, checked by the predictor.
      add_row(lkvc_pkg::OP_PUT, 32'h55555555, 32'haaaaaaaa, 0, 0, 0, 0, 0);
      add_row(lkvc_pkg::OP_GET, 32'h55555555, 32'h0, 0, 0, 0, 0, 0);
      add_row(lkvc_pkg::OP_PUT, 32'haaaaaaaa, 32'h55555555, 0, 0, 0, 0, 0);
      add_row(lkvc_pkg::OP_GET, INT_MIN, 32'h0, 0, 0, 0, 0, 0);
      add_row(lkvc_pkg::OP_GET, 32'haaaaaaaa, 32'h0, 0, 0, 0, 0, 0);
      add_row(lkvc_pkg::OP_PUT, 32'h0000ffff, 32'hffff0000, 0, 0, 0, 0, 0);
      add_row(lkvc_pkg::OP_GET, 32'h0000ffff, 32'h0, 0, 0, 0, 0, 0);

      repeat (2) @(posedge clock);
      reset <= 1'b0;
      write_capacity(DIRECTED_CAP);
      foreach (directed_rows[i]) begin
         send_request(directed_rows[i].req, directed_rows[i].pinned, directed_rows[i].rsp, 0);
      end

      // Capacities include zero, one, the full size, above the full size and a lowered fill.
      for (int p = 0; p < PHASE_COUNT; p++) begin
         drain();
         write_capacity(phase_cap[p]);
         refresh_pool();
         for (int n = 0; n < PHASE_WORDS; n++) begin
            send_request(random_request(), 1'b0, '0, phase_idle[p]);
         end
      end

      drain();
      repeat (4) @(posedge clock);
      if (!failed) begin
         $display("lru_key_value_cache_tb: PASS");
      end else begin
         $display("lru_key_value_cache_tb: FAIL");
      end
      $finish;
   end

endmodule
